[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the GGA parser RTL.
// ----------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on the module's own clock, masked while reset is high.
`define GSP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Same, with an explicit clock and reset.
`define GSP_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

`endif

[rtl/core/gsp_pkg.sv]
// ----------------------------------------------------------------------
// GGA parser package
// Character codes, field numbers, scaling constants and shared types.
// ----------------------------------------------------------------------
package gsp_pkg;

   // ASCII codes
   localparam logic [7:0] CHAR_G     = 8'h47;
   localparam logic [7:0] CHAR_P     = 8'h50;
   localparam logic [7:0] CHAR_A     = 8'h41;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_S     = 8'h53;
   localparam logic [7:0] CHAR_W     = 8'h57;
   localparam logic [7:0] CHAR_ONE   = 8'h31;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Line position: five header bytes, one skipped byte, then the body
   localparam logic [2:0] POS_SKIP = 3'd5;
   localparam logic [2:0] POS_BODY = 3'd6;

   // Body field numbers
   localparam logic [2:0] FLD_TIME  = 3'd0;
   localparam logic [2:0] FLD_LAT   = 3'd1;
   localparam logic [2:0] FLD_NS    = 3'd2;
   localparam logic [2:0] FLD_LON   = 3'd3;
   localparam logic [2:0] FLD_EW    = 3'd4;
   localparam logic [2:0] FLD_FIX   = 3'd5;
   localparam logic [2:0] FLD_SATS  = 3'd6;
   localparam logic [2:0] FLD_EXTRA = 3'd7;

   // ddmm.mmmm to micro-degrees: q = x / 1e6 by reciprocal, r*5/3 likewise
   localparam logic [19:0] COORD_SCALE = 20'd1000000;
   localparam logic [30:0] SCALE_RECIP = 31'd1125899906;   // floor(2^50 / 1e6)
   localparam int          SCALE_SHIFT = 50;
   localparam int          QUO_W       = 12;
   localparam logic [22:0] THIRD_RECIP = 23'd5592406;      // ceil(2^24 / 3)
   localparam int          THIRD_SHIFT = 24;
   localparam int          FRAC_W      = 21;

   // Front-to-back queue
   localparam int               QUEUE_DEPTH = 4;
   localparam int               QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam logic [QUEUE_AW:0] QUEUE_FULL = (QUEUE_AW + 1)'(QUEUE_DEPTH);

   // One field-close or end-of-line request from front to back
   typedef struct packed {
      logic        is_end;
      logic        accepted;
      logic [2:0]  idx;
      logic [1:0]  chars;
      logic [7:0]  first;
      logic [7:0]  second;
      logic [31:0] acc;
   } evt_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Expected header character at a header position
   function automatic logic [7:0] header_char(input logic [2:0] pos);
      logic [7:0] ch;
      unique case (pos)
         3'd1:    ch = CHAR_P;
         3'd4:    ch = CHAR_A;
         default: ch = CHAR_G;
      endcase
      return ch;
   endfunction

endpackage

[rtl/core/gsp_req_if.sv]
// ----------------------------------------------------------------------
// GGA parser request channel
// One sentence byte per request, with an end-of-line flag.
// ----------------------------------------------------------------------
interface gsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] line_byte;
   logic       line_end;

   modport source (output valid, line_byte, line_end, input ready);
   modport sink   (input valid, line_byte, line_end, output ready);
endinterface

[rtl/core/gsp_rsp_if.sv]
// ----------------------------------------------------------------------
// GGA parser response channel
// One result per sentence: flags and the held position and count.
// ----------------------------------------------------------------------
interface gsp_rsp_if;
   logic               valid;
   logic               ready;
   logic               gga_line;
   logic               fix_ok;
   logic signed [31:0] latitude;
   logic signed [31:0] longitude;
   logic [11:0]        satellites;

   modport source (output valid, gga_line, fix_ok, latitude, longitude, satellites,
                   input ready);
   modport sink   (input valid, gga_line, fix_ok, latitude, longitude, satellites,
                   output ready);
endinterface

[rtl/core/gga_sentence_parser.sv]
// ----------------------------------------------------------------------
// GGA sentence parser
// Byte-serial NMEA GGA parser: header check, field split, coordinate
// conversion to micro-degrees and held position / satellite count.
//
//   channel | dir | handshake   | payload
//   req_ch  | in  | valid/ready | line_byte[7:0], line_end
//   rsp_ch  | out | valid/ready | gga_line, fix_ok, latitude, longitude,
//           |     |             | satellites[11:0]
//
// One byte per cycle sustained; the front end takes a byte every cycle
// while the 4-entry request queue has room.
// A line end reaches its response through the queue, six
// conversion stages (two reciprocal multiplies), then the commit register.
// Reset is synchronous; held values clear to zero, no clearing pass.
// A stalled response freezes the back end; the queue absorbs up to four
// field-close or line-end requests before req_ch.ready drops.
// ----------------------------------------------------------------------
module gga_sentence_parser (
   input  logic      clock,
   input  logic      reset,
   gsp_req_if.sink   req_ch,
   gsp_rsp_if.source rsp_ch
);
   import gsp_pkg::*;

   logic      req_accept;
   logic      push;
   logic      pop;
   evt_type   push_evt;
   evt_type   head_evt;
   qstat_type qstat;

   assign req_ch.ready = !qstat.full;
   assign req_accept   = req_ch.valid && req_ch.ready;

   gsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_byte   (req_ch.line_byte),
      .req_last   (req_ch.line_end),
      .push       (push),
      .push_evt   (push_evt)
   );

   gsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_evt (push_evt),
      .pop      (pop),
      .head_evt (head_evt),
      .stat     (qstat)
   );

   gsp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_evt (head_evt),
      .qstat    (qstat),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

[rtl/core/gsp_front.sv]
// ----------------------------------------------------------------------
// GGA parser front end
// Checks the header, splits the body on commas, collects field characters
// and digits, and emits a request at each field close and at line end.
// ----------------------------------------------------------------------
`include "assert_macros.svh"

module gsp_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_accept,
   input  logic [7:0]      req_byte,
   input  logic            req_last,
   output logic            push,
   output gsp_pkg::evt_type push_evt
);
   import gsp_pkg::*;

   logic [2:0]  hdr_pos_ff, hdr_pos_in;
   logic        hdr_match_ff, hdr_match_in;
   logic [2:0]  fld_idx_ff, fld_idx_in;
   logic [1:0]  fld_chars_ff, fld_chars_in;
   logic [31:0] digit_acc_ff, digit_acc_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  second_ff, second_in;

   logic        in_body;
   logic        is_comma;
   logic        is_digit;
   logic [1:0]  chars_upd;
   logic [7:0]  first_upd;
   logic [7:0]  second_upd;
   logic [31:0] acc_upd;

   assign in_body  = (hdr_pos_ff == POS_BODY) && hdr_match_ff;
   assign is_comma = (req_byte == CHAR_COMMA);
   assign is_digit = (req_byte >= CHAR_ZERO) && (req_byte <= CHAR_NINE);

   // Field registers after taking one non-comma character
   always_comb begin
      first_upd  = (fld_chars_ff == 2'd0) ? req_byte : first_ff;
      second_upd = (fld_chars_ff == 2'd1) ? req_byte : second_ff;
      chars_upd  = (fld_chars_ff == 2'd3) ? fld_chars_ff : fld_chars_ff + 2'd1;
      // acc * 10 + digit, wrapping at 32 bits
      acc_upd    = is_digit ? ({digit_acc_ff[28:0], 3'b000} + {digit_acc_ff[30:0], 1'b0}
                               + {24'd0, req_byte - CHAR_ZERO})
                            : digit_acc_ff;
   end

   // Line tracking
   always_comb begin
      hdr_pos_in   = hdr_pos_ff;
      hdr_match_in = hdr_match_ff;
      fld_idx_in   = fld_idx_ff;
      fld_chars_in = fld_chars_ff;
      digit_acc_in = digit_acc_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      if (req_accept) begin
         if (hdr_pos_ff < POS_SKIP) begin
            hdr_pos_in = hdr_pos_ff + 3'd1;
            if (req_byte != header_char(hdr_pos_ff)) begin
               hdr_match_in = 1'b0;
            end
         end else if (hdr_pos_ff == POS_SKIP) begin
            hdr_pos_in = POS_BODY;
         end else if (in_body) begin
            if (is_comma) begin
               fld_idx_in   = (fld_idx_ff == FLD_EXTRA) ? fld_idx_ff : fld_idx_ff + 3'd1;
               fld_chars_in = 2'd0;
               digit_acc_in = 32'd0;
               first_in     = 8'd0;
               second_in    = 8'd0;
            end else begin
               fld_chars_in = chars_upd;
               digit_acc_in = acc_upd;
               first_in     = first_upd;
               second_in    = second_upd;
            end
         end
         // end of line: back to the start of a new sentence
         if (req_last) begin
            hdr_pos_in   = 3'd0;
            hdr_match_in = 1'b1;
            fld_idx_in   = FLD_TIME;
            fld_chars_in = 2'd0;
            digit_acc_in = 32'd0;
            first_in     = 8'd0;
            second_in    = 8'd0;
         end
      end
   end

   // Request to the back end. A final comma carries the pre-comma field:
   // the empty field after it closes like any missing field.
   assign push = req_accept && (req_last || (in_body && is_comma));

   always_comb begin
      push_evt.is_end   = req_last;
      push_evt.accepted = (hdr_pos_ff >= POS_SKIP) && hdr_match_ff;
      push_evt.idx      = fld_idx_ff;
      if (in_body && !is_comma) begin
         push_evt.chars  = chars_upd;
         push_evt.first  = first_upd;
         push_evt.second = second_upd;
         push_evt.acc    = acc_upd;
      end else begin
         push_evt.chars  = fld_chars_ff;
         push_evt.first  = first_ff;
         push_evt.second = second_ff;
         push_evt.acc    = digit_acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_pos_ff   <= 3'd0;
         hdr_match_ff <= 1'b1;
         fld_idx_ff   <= FLD_TIME;
         fld_chars_ff <= 2'd0;
         digit_acc_ff <= 32'd0;
         first_ff     <= 8'd0;
         second_ff    <= 8'd0;
      end else begin
         hdr_pos_ff   <= hdr_pos_in;
         hdr_match_ff <= hdr_match_in;
         fld_idx_ff   <= fld_idx_in;
         fld_chars_ff <= fld_chars_in;
         digit_acc_ff <= digit_acc_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
      end
   end

   // A line end always restarts header and field tracking
   `GSP_ASSERT(a_line_restart, (req_accept && req_last) |=> ((hdr_pos_ff == 3'd0) && (fld_idx_ff == FLD_TIME) && hdr_match_ff), "line end did not restart parsing")

endmodule

[rtl/core/gsp_queue.sv]
// ----------------------------------------------------------------------
// GGA parser request queue
// Small FIFO between the front end and the conversion back end.
// ----------------------------------------------------------------------
`include "assert_macros.svh"

module gsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  gsp_pkg::evt_type  push_evt,
   input  logic              pop,
   output gsp_pkg::evt_type  head_evt,
   output gsp_pkg::qstat_type stat
);
   import gsp_pkg::*;

   evt_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign stat.full  = (count_ff == QUEUE_FULL);
   assign stat.empty = (count_ff == '0);
   assign head_evt   = slot_ff[rd_ptr_ff];

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_evt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `GSP_ASSERT(a_count_up, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1), "queue overrun on push")
   `GSP_ASSERT_CLK(a_count_down, clock, reset, (pop && !push) |=> (count_ff == $past(count_ff) - 1'b1), "queue underrun on pop")

endmodule

[rtl/core/gsp_back.sv]
// ----------------------------------------------------------------------
// GGA parser back end
// Six-stage coordinate conversion followed by the field-close commit,
// which updates the held values and loads the response register.
// ----------------------------------------------------------------------
`include "assert_macros.svh"

module gsp_back (
   input  logic               clock,
   input  logic               reset,
   input  gsp_pkg::evt_type   head_evt,
   input  gsp_pkg::qstat_type qstat,
   output logic               pop,
   gsp_rsp_if.source          rsp_ch
);
   import gsp_pkg::*;

   typedef struct packed {
      evt_type     evt;
      logic [31:0] mag;
      logic        neg;
   } carry_type;

   logic            en;
   logic [6:1]      vld_ff;
   carry_type       carry_ff [1:6];
   carry_type       carry_in;

   logic [62:0]      scale_prod;
   logic [QUO_W-1:0] s2_quo_ff;
   logic [31:0]      quo_scaled;
   logic [31:0]      rem_wide;
   logic [20:0]      s3_rem_ff;
   logic [20:0]      rem_fix;
   logic [19:0]      s4_rem_ff;
   logic [22:0]      s4_rem5_ff;
   logic [45:0]      third_prod;
   logic [19:0]      s5_rem_ff;
   logic [FRAC_W-1:0] s5_frac_ff;
   logic [31:0]      mag_out;
   logic [31:0]      s6_value_ff;

   logic [31:0] coord_ff, coord_in;
   logic        fix_ff, fix_in;
   logic [31:0] lat_ff, lat_in;
   logic [31:0] lon_ff, lon_in;
   logic [11:0] sats_ff, sats_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        gga_ff, gga_in;
   logic        fix_ok_ff, fix_ok_in;

   evt_type     c_evt;
   logic        has_chars;
   logic [7:0]  dig0, dig1;
   logic [11:0] sats_calc;
   logic [31:0] coord_c, lat_c, lon_c;
   logic        fix_c;
   logic [11:0] sats_c;

   // The whole back end advances unless a response waits
   assign en  = !rsp_valid_ff || rsp_ch.ready;
   assign pop = en && !qstat.empty;

   // Stage 1 input: sign and magnitude of the digit accumulator
   always_comb begin
      carry_in.evt = head_evt;
      carry_in.neg = head_evt.acc[31];
      carry_in.mag = head_evt.acc[31] ? 32'd0 - head_evt.acc : head_evt.acc;
   end

   // Stage 2: quotient estimate by reciprocal, floor or one below
   assign scale_prod = carry_ff[1].mag * SCALE_RECIP;

   // Stage 3: remainder against the estimate, below twice the scale
   assign quo_scaled = {20'd0, s2_quo_ff} * {12'd0, COORD_SCALE};
   assign rem_wide   = carry_ff[2].mag - quo_scaled;

   // Stage 4: one correction step
   assign rem_fix = (s3_rem_ff >= {1'b0, COORD_SCALE}) ? s3_rem_ff - {1'b0, COORD_SCALE}
                                                       : s3_rem_ff;

   // Stage 5: remainder * 5 / 3 by reciprocal
   assign third_prod = s4_rem5_ff * THIRD_RECIP;

   // Stage 6: q * 1e6 + r * 5 / 3 = mag - r + r * 5 / 3, sign restored
   assign mag_out = carry_ff[5].mag - {12'd0, s5_rem_ff} + {11'd0, s5_frac_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         carry_ff[1] <= carry_in;
         for (int k = 2; k <= 6; k++) begin
            carry_ff[k] <= carry_ff[k - 1];
         end
         s2_quo_ff   <= scale_prod[SCALE_SHIFT +: QUO_W];
         s3_rem_ff   <= rem_wide[20:0];
         s4_rem_ff   <= rem_fix[19:0];
         s4_rem5_ff  <= {1'b0, rem_fix[19:0], 2'b00} + {3'd0, rem_fix[19:0]};
         s5_rem_ff   <= s4_rem_ff;
         s5_frac_ff  <= third_prod[THIRD_SHIFT +: FRAC_W];
         s6_value_ff <= carry_ff[5].neg ? 32'd0 - mag_out : mag_out;
      end
   end

   // Field close of the committing request
   assign c_evt     = carry_ff[6].evt;
   assign has_chars = (c_evt.chars != 2'd0);
   assign dig0      = c_evt.first - CHAR_ZERO;
   assign dig1      = c_evt.second - CHAR_ZERO;
   assign sats_calc = {4'd0, dig0} * 12'd10 + {4'd0, dig1};

   always_comb begin
      coord_c = coord_ff;
      lat_c   = lat_ff;
      lon_c   = lon_ff;
      fix_c   = fix_ff;
      sats_c  = sats_ff;
      unique case (c_evt.idx)
         FLD_LAT, FLD_LON: coord_c = s6_value_ff;
         FLD_NS:  lat_c = (has_chars && (c_evt.first == CHAR_S)) ? 32'd0 - coord_ff : coord_ff;
         FLD_EW:  lon_c = (has_chars && (c_evt.first == CHAR_W)) ? 32'd0 - coord_ff : coord_ff;
         FLD_FIX: fix_c = has_chars && (c_evt.first == CHAR_ONE);
         FLD_SATS: begin
            if (fix_ff && (c_evt.chars >= 2'd2)) begin
               sats_c = sats_calc;
            end else begin
               fix_c = 1'b0;
            end
         end
         default: ;
      endcase
   end

   // Commit: a field close updates the line state; a line end also closes
   // every missing field (empty) and loads the response
   always_comb begin
      coord_in     = coord_ff;
      fix_in       = fix_ff;
      lat_in       = lat_ff;
      lon_in       = lon_ff;
      sats_in      = sats_ff;
      rsp_valid_in = rsp_valid_ff;
      gga_in       = gga_ff;
      fix_ok_in    = fix_ok_ff;
      if (en) begin
         rsp_valid_in = vld_ff[6] && c_evt.is_end;
         if (vld_ff[6]) begin
            if (!c_evt.is_end) begin
               coord_in = coord_c;
               fix_in   = fix_c;
               lat_in   = lat_c;
               lon_in   = lon_c;
               sats_in  = sats_c;
            end else begin
               coord_in  = 32'd0;
               fix_in    = 1'b0;
               gga_in    = c_evt.accepted;
               fix_ok_in = 1'b0;
               if (c_evt.accepted) begin
                  lat_in    = (c_evt.idx == FLD_TIME) ? 32'd0 :
                              (c_evt.idx == FLD_LAT) ? coord_c : lat_c;
                  lon_in    = (c_evt.idx <= FLD_NS) ? 32'd0 :
                              (c_evt.idx == FLD_LON) ? coord_c : lon_c;
                  sats_in   = sats_c;
                  fix_ok_in = (c_evt.idx >= FLD_SATS) && fix_c;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         coord_ff     <= 32'd0;
         fix_ff       <= 1'b0;
         lat_ff       <= 32'd0;
         lon_ff       <= 32'd0;
         sats_ff      <= 12'd0;
         rsp_valid_ff <= 1'b0;
         gga_ff       <= 1'b0;
         fix_ok_ff    <= 1'b0;
      end else begin
         if (en) begin
            vld_ff <= {vld_ff[5:1], pop};
         end
         coord_ff     <= coord_in;
         fix_ff       <= fix_in;
         lat_ff       <= lat_in;
         lon_ff       <= lon_in;
         sats_ff      <= sats_in;
         rsp_valid_ff <= rsp_valid_in;
         gga_ff       <= gga_in;
         fix_ok_ff    <= fix_ok_in;
      end
   end

   // Response reads the held values directly; they only move on a commit
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.gga_line   = gga_ff;
   assign rsp_ch.fix_ok     = fix_ok_ff;
   assign rsp_ch.latitude   = $signed(lat_ff);
   assign rsp_ch.longitude  = $signed(lon_ff);
   assign rsp_ch.satellites = sats_ff;

   `GSP_ASSERT(a_hold_stall, (rsp_valid_ff && !rsp_ch.ready) |=> ($stable(lat_ff) && $stable(lon_ff) && $stable(sats_ff)), "held values moved under a stalled response")
   `GSP_ASSERT(a_pipe_freeze, !en |=> $stable(vld_ff), "conversion pipeline moved while stalled")

endmodule

[tb/tb_gga_sentence_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------
// GGA sentence parser testbench
// Feeds sentence bytes through the request channel, tracks the parser
// state in a behavioral copy and checks every response field by field.
// Directed sentences come first, then random sentences with random
// idling on both sides, a long response stall and a full drain.
// ----------------------------------------------------------------------
module tb_gga_sentence_parser;
   import gsp_pkg::*;

   typedef struct packed {
      logic               gga_line;
      logic               fix_ok;
      logic signed [31:0] latitude;
      logic signed [31:0] longitude;
      logic [11:0]        satellites;
   } report_type;

   localparam longint     MICRO   = COORD_SCALE;
   localparam logic [39:0] GGA_TAG = {CHAR_G, CHAR_P, CHAR_G, CHAR_G, CHAR_A};

   logic clock = 1'b0;
   logic reset = 1'b1;

   gsp_req_if req_ch ();
   gsp_rsp_if rsp_ch ();

   gga_sentence_parser DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #2 clock = ~clock;

   // Parser state as the block should hold it
   logic [2:0]  hdr_pos;
   logic        hdr_ok;
   logic [2:0]  fld_num;
   logic [1:0]  fld_len;
   logic [31:0] digits;
   logic [7:0]  c_first;
   logic [7:0]  c_second;
   logic [31:0] coord;
   logic        fix_one;
   logic [31:0] lat_keep;
   logic [31:0] lon_keep;
   logic [11:0] sats_keep;

   report_type  reports_due [$];
   logic [7:0]  line_buf [$];
   string       script_text [$];
   bit          script_typed [$];
   report_type  script_want [$];

   int faults       = 0;
   int reports_seen = 0;
   int sent_bytes   = 0;
   bit calm         = 1'b0;

   // ddmm.mmmm digits to micro-degrees, all in 32-bit wraparound
   function automatic logic [31:0] to_micro_deg(logic [31:0] acc);
      longint s, q, r, v;
      s = longint'($signed(acc));
      q = s / MICRO;
      r = s % MICRO;
      v = q * MICRO + (r * 5) / 3;
      return v[31:0];
   endfunction

   function void clear_field();
      fld_len  = 2'd0;
      digits   = 32'd0;
      c_first  = 8'd0;
      c_second = 8'd0;
   endfunction

   function void clear_line();
      hdr_pos = 3'd0;
      hdr_ok  = 1'b1;
      fld_num = FLD_TIME;
      clear_field();
      coord   = 32'd0;
      fix_one = 1'b0;
   endfunction

   function void close_field(logic [2:0] idx);
      logic [7:0] d0, d1;
      d0 = c_first - CHAR_ZERO;
      d1 = c_second - CHAR_ZERO;
      case (idx)
         FLD_LAT, FLD_LON: coord = to_micro_deg(digits);
         FLD_NS:  lat_keep = (fld_len != 0 && c_first == CHAR_S) ? 32'd0 - coord : coord;
         FLD_EW:  lon_keep = (fld_len != 0 && c_first == CHAR_W) ? 32'd0 - coord : coord;
         FLD_FIX: fix_one = (fld_len != 0 && c_first == CHAR_ONE);
         FLD_SATS: begin
            if (fix_one && fld_len >= 2) sats_keep = 12'(d0 * 12'd10 + d1);
            else fix_one = 1'b0;
         end
         default: ;
      endcase
   endfunction

   // Advance the parser by one byte; returns 1 when the byte ends a line
   function bit parse_gga_byte(logic [7:0] ch, logic last, output report_type rep);
      bit taken;
      int k;
      taken = 1'b0;
      if (hdr_pos < POS_SKIP) begin
         if (ch != GGA_TAG[8*(4-hdr_pos) +: 8]) hdr_ok = 1'b0;
         hdr_pos++;
      end else if (hdr_pos == POS_SKIP) begin
         hdr_pos = POS_BODY;
         taken   = last && hdr_ok;
      end else begin
         if (hdr_ok) begin
            if (ch == CHAR_COMMA) begin
               close_field(fld_num);
               if (fld_num != FLD_EXTRA) fld_num++;
               clear_field();
            end else begin
               if (fld_len == 0) c_first = ch;
               else if (fld_len == 1) c_second = ch;
               if (fld_len != 2'd3) fld_len++;
               if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                  digits = digits * 10 + 32'(ch - CHAR_ZERO);
            end
         end
         taken = last && hdr_ok;
      end
      if (!last) return 1'b0;
      // close the open field, absent fields count as empty
      if (taken) begin
         close_field(fld_num);
         for (k = int'(fld_num) + 1; k <= int'(FLD_SATS); k++) begin
            clear_field();
            close_field(3'(k));
         end
      end
      rep = '{taken, taken && fix_one, lat_keep, lon_keep, sats_keep};
      clear_line();
      return 1'b1;
   endfunction

   function void add_line(string text, bit typed = 1'b0, bit gga = 1'b0, bit fix = 1'b0,
                          int sats = 0);
      report_type w;
      w = '{gga, fix, 32'sd0, 32'sd0, sats[11:0]};
      script_text.push_back(text);
      script_typed.push_back(typed);
      script_want.push_back(w);
   endfunction

   function void add_digits(int n);
      repeat (n) line_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
   endfunction

   function void add_noise(int n);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Send line_buf one request per byte, end flag on the last byte
   task automatic send_line(bit typed, report_type want);
      report_type rep;
      logic       last;
      for (int i = 0; i < line_buf.size(); i++) begin
         last = (i == line_buf.size() - 1);
         if (!calm && $urandom_range(0, 4) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         req_ch.valid     <= 1'b1;
         req_ch.line_byte <= line_buf[i];
         req_ch.line_end  <= last;
         do @(posedge clock); while (req_ch.ready !== 1'b1);
         sent_bytes++;
         if (parse_gga_byte(line_buf[i], last, rep))
            reports_due.push_back(typed ? want : rep);
      end
   endtask

   // Stimulus
   initial begin
      logic [7:0] ch;
      string      s;
      int         kind;
      int         n;
      int         lines;
      req_ch.valid     <= 1'b0;
      req_ch.line_byte <= 8'h00;
      req_ch.line_end  <= 1'b0;
      lat_keep  = 32'd0;
      lon_keep  = 32'd0;
      sats_keep = 12'd0;
      clear_line();
      lines = 0;

      // '#' stands for a zero byte and '~' for 8'hFF
      add_line("GP", 1'b1);                          // short line after reset
      add_line("GPGGA", 1'b1);                       // ends on the fifth byte
      add_line("GPGGA,", 1'b1, 1'b1);                // ends on the skipped byte
      add_line("XPGGA,9,1,S,1,W,1,99", 1'b1);        // header mismatch
      add_line("GPGGA,,,,,,1,07", 1'b1, 1'b1, 1'b1, 7);
      add_line("GPGGA,,,,,,1,//", 1'b1, 1'b1, 1'b1, 2805);
      add_line("GPGGA,,,,,,1,~~", 1'b1, 1'b1, 1'b1, 2277);
      add_line("GPGGA,,,,,,1,5", 1'b1, 1'b1, 1'b0, 2277);   // one sats char
      add_line("GPGGA,,,,,,2,55", 1'b1, 1'b1, 1'b0, 2277);  // no fix
      add_line("GPGGA,1,4807.038,N,01131.000,E,1,08,0.9");
      add_line("GPGGA,1,4807.038,S,01131.000,W,1,12");
      add_line("GPGGA,,99999999999999,S,4294967295,W,1,00");
      add_line("GPGGA,,2147483648,S,2147483647,E,1,10");
      add_line("GPGGA#,#12#3,#,#,,#");
      add_line("GPGGA,1,4807.038");                 // missing fields
      add_line("GPGGAx");
      add_line("GPGGA,,,,,,,,,,,,1,22");
      add_line("GPGGA,1,2,S,3,W,1,10,,,,");
      add_line("~");

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed sentences
      for (int i = 0; i < script_text.size(); i++) begin
         s = script_text[i];
         line_buf.delete();
         for (int j = 0; j < s.len(); j++) begin
            ch = s[j];
            if (ch == "#") ch = 8'h00;
            else if (ch == "~") ch = 8'hFF;
            line_buf.push_back(ch);
         end
         send_line(script_typed[i], script_want[i]);
      end

      // Random sentences: mostly well formed, some noise and broken headers
      while (sent_bytes < 1900) begin
         line_buf.delete();
         kind = $urandom_range(0, 99);
         if (kind < 10) begin
            add_noise($urandom_range(1, 12));
         end else begin
            for (int k = 0; k < 5; k++) line_buf.push_back(GGA_TAG[8*(4-k) +: 8]);
            if (kind < 20) line_buf[$urandom_range(0, 4)] = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 7) == 0) add_noise(1);
            else line_buf.push_back(CHAR_COMMA);
            add_digits($urandom_range(0, 6));
            line_buf.push_back(CHAR_COMMA);
            // latitude, hemisphere, longitude, hemisphere
            for (int c = 0; c < 2; c++) begin
               if ($urandom_range(0, 9) == 0) begin
                  add_digits($urandom_range(8, 14));
               end else begin
                  add_digits($urandom_range(0, 4));
                  line_buf.push_back(".");
                  add_digits($urandom_range(0, 4));
               end
               if ($urandom_range(0, 9) == 0) add_noise(1);
               line_buf.push_back(CHAR_COMMA);
               case ($urandom_range(0, 5))
                  1, 2: line_buf.push_back(c == 0 ? "N" : "E");
                  3, 4: line_buf.push_back(c == 0 ? CHAR_S : CHAR_W);
                  5:    add_noise(1);
                  default: ;
               endcase
               line_buf.push_back(CHAR_COMMA);
            end
            // fix quality
            case ($urandom_range(0, 6))
               1, 2, 3: line_buf.push_back(CHAR_ONE);
               4:       line_buf.push_back(CHAR_ZERO);
               5:       line_buf.push_back("2");
               6:       add_noise(1);
               default: ;
            endcase
            if ($urandom_range(0, 5) == 0) add_noise(1);
            line_buf.push_back(CHAR_COMMA);
            // satellites
            n = $urandom_range(0, 3);
            if ($urandom_range(0, 4) == 0) add_noise(n);
            else add_digits(n);
            repeat ($urandom_range(0, 3)) begin
               line_buf.push_back(CHAR_COMMA);
               add_digits($urandom_range(0, 3));
            end
            if ($urandom_range(0, 7) == 0) begin
               n = $urandom_range(1, line_buf.size());
               while (line_buf.size() > n) void'(line_buf.pop_back());
            end
         end
         send_line(1'b0, '0);
         lines++;
         // hold the input until every response is back
         if (lines == 20) begin
            req_ch.valid <= 1'b0;
            do @(posedge clock); while (reports_due.size() != 0);
         end
         if (sent_bytes >= 1600) calm = 1'b1;
      end

      req_ch.valid <= 1'b0;
      do @(posedge clock); while (reports_due.size() != 0);
      repeat (20) @(posedge clock);
      if (faults == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   // Response side: random stalls and one long hold-off
   initial begin
      bit held_off;
      held_off = 1'b0;
      rsp_ch.ready <= 1'b0;
      repeat (10) @(posedge clock);
      forever begin
         if (!held_off && reports_seen >= 30) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 24)) @(posedge clock);
      end
   end

   // Response check against the oldest expectation
   always @(posedge clock) begin
      report_type w;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         reports_seen++;
         if (reports_due.size() == 0) begin
            faults++;
            if (faults <= 10) $display("%0t: response with none expected", $time);
         end else begin
            w = reports_due.pop_front();
            if (rsp_ch.gga_line !== w.gga_line || rsp_ch.fix_ok !== w.fix_ok ||
                rsp_ch.latitude !== w.latitude || rsp_ch.longitude !== w.longitude ||
                rsp_ch.satellites !== w.satellites) begin
               faults++;
               if (faults <= 10)
                  $display("%0t: expected gga=%0b fix=%0b lat=%0d lon=%0d sats=%0d,",
                           $time, w.gga_line, w.fix_ok, w.latitude, w.longitude,
                           w.satellites, " got gga=%0b fix=%0b lat=%0d lon=%0d sats=%0d",
                           rsp_ch.gga_line, rsp_ch.fix_ok, rsp_ch.latitude,
                           rsp_ch.longitude, rsp_ch.satellites);
            end
         end
      end
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
